// ===== sv/q4kd_pkg.sv =====
// ----------------------------------------------------------------------------
// q4kd_pkg
// shared types and constants of the q4_k block dequantizer
// ----------------------------------------------------------------------------
`default_nettype none
package q4kd_pkg;

	// item kinds on the input tuser
	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_DATA   = 1'b1;

	// unpacking masks
	localparam logic [7:0] MASK_SIX  = 8'h3F;
	localparam logic [7:0] MASK_TWO  = 8'h03;
	localparam logic [7:0] MASK_NIB  = 8'h0F;

	// float32 codes
	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [30:0] INF_BITS  = 31'h7F80_0000;

	// aligned magnitude width: 21-bit product shifted by up to 29
	localparam int MAG_W = 50;
	localparam int POS_W = 6;

	// controller to datapath commands
	typedef struct packed {
		logic load_hdr;
		logic load_data;
		logic st_mul;
		logic st_prod;
		logic st_align;
		logic st_scan;
		logic ld_out;
	} cmd_t;

endpackage
`default_nettype wire

// ===== sv/q4_k_block_dequantizer_core.sv =====
// ----------------------------------------------------------------------------
// q4_k_block_dequantizer_core
// streaming dequantizer for 4-bit k-quant weight blocks
// ----------------------------------------------------------------------------
// A header beat (tuser 0) loads the block's fp16 scale and min multipliers and
// unpacks its 12 scale bytes into eight 6-bit group scales and mins; it gives
// no output and restarts the block position. Each data beat (tuser 1) carries
// one byte of two 4-bit codes and yields one output beat with two float32
// values d*scale*q - dmin*min, exact products and one round-to-nearest-even;
// any nan comes out as 0x7FC00000. A data beat closes the input until the
// sequencer has walked it through group multiply, code multiply, aligned
// subtract, leading one scan and rounding and loaded the output register. The
// output register lets a finished beat wait on m_tready while the next input
// is accepted. tlast marks the last byte of a block; after it the position
// wraps and the last header is reused.
// ----------------------------------------------------------------------------
`default_nettype none
module q4_k_block_dequantizer_core #(
	parameter int BLOCK_VALUES = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic         s_tuser,   // kind
	// half_scale[15:0], half_min[31:16], scale_bytes_low[79:32],
	// scale_bytes_high[127:80], packed_byte[135:128]
	input  wire logic [135:0] s_tdata,
	// output stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// low_value[31:0], high_value[63:32], value_index[71:64]
	output logic [71:0]       m_tdata,
	output logic              m_tlast    // block_end
);

	localparam int VI_W = $clog2(BLOCK_VALUES);

	q4kd_pkg::cmd_t  cmd;
	logic [31:0]     low_value, high_value;
	logic [VI_W-1:0] value_index;

	// sequencer
	q4kd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_kind   (s_tuser),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.cmd       (cmd)
	);

	// arithmetic and header store
	q4kd_dp #(
		.BLOCK_VALUES(BLOCK_VALUES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.half_scale       (s_tdata[15:0]),
		.half_min         (s_tdata[31:16]),
		.scale_bytes_low  (s_tdata[79:32]),
		.scale_bytes_high (s_tdata[127:80]),
		.packed_byte      (s_tdata[135:128]),
		.low_value        (low_value),
		.high_value       (high_value),
		.value_index      (value_index),
		.block_end        (m_tlast)
	);

	// pack the output beat
	assign m_tdata = {8'(value_index), high_value, low_value};

endmodule
`default_nettype wire

// ===== sv/q4kd_ctrl.sv =====
// ----------------------------------------------------------------------------
// q4kd_ctrl
// sequencer: accepts beats and steps the datapath through its stages
// ----------------------------------------------------------------------------
`default_nettype none
module q4kd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_kind,
	output logic               in_ready,
	input  wire logic          out_ready,
	output logic               out_valid,
	output q4kd_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_PROD, ST_ALIGN, ST_SCAN, ST_ROUND
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   take;
	logic   ld;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign take      = in_valid && in_ready;
	assign ld        = (state_q == ST_ROUND) && (!out_valid_q || out_ready);

	always_comb begin
		cmd           = '0;
		cmd.load_hdr  = take && (in_kind == q4kd_pkg::KIND_HEADER);
		cmd.load_data = take && (in_kind == q4kd_pkg::KIND_DATA);
		cmd.st_mul    = (state_q == ST_MUL);
		cmd.st_prod   = (state_q == ST_PROD);
		cmd.st_align  = (state_q == ST_ALIGN);
		cmd.st_scan   = (state_q == ST_SCAN);
		cmd.ld_out    = ld;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (ld) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take && in_kind == q4kd_pkg::KIND_DATA) state_q <= ST_MUL;
				end
				ST_MUL:   state_q <= ST_PROD;
				ST_PROD:  state_q <= ST_ALIGN;
				ST_ALIGN: state_q <= ST_SCAN;
				ST_SCAN:  state_q <= ST_ROUND;
				ST_ROUND: begin
					if (ld) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/q4kd_dp.sv =====
// ----------------------------------------------------------------------------
// q4kd_dp
// datapath: header store, exact products, aligned subtract, rounding
// ----------------------------------------------------------------------------
`default_nettype none
module q4kd_dp #(
	parameter int BLOCK_VALUES = 256
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire q4kd_pkg::cmd_t                    cmd,
	input  wire logic [15:0]                       half_scale,
	input  wire logic [15:0]                       half_min,
	input  wire logic [47:0]                       scale_bytes_low,
	input  wire logic [47:0]                       scale_bytes_high,
	input  wire logic [7:0]                        packed_byte,
	output logic [31:0]                            low_value,
	output logic [31:0]                            high_value,
	output logic [$clog2(BLOCK_VALUES)-1:0]        value_index,
	output logic                                   block_end
);

	localparam int BP_W = $clog2(BLOCK_VALUES / 2);
	localparam int VI_W = $clog2(BLOCK_VALUES);
	localparam int G_W  = BP_W - 4;
	localparam logic [BP_W-1:0] LAST_POS = BP_W'(BLOCK_VALUES / 2 - 1);
	localparam int MW   = q4kd_pkg::MAG_W;
	localparam int PW   = q4kd_pkg::POS_W;

	// header state
	logic [15:0]     hsc_q, hmn_q;
	logic [5:0]      gsc_q [8];
	logic [5:0]      gmn_q [8];
	logic [BP_W-1:0] pos_q;
	logic [7:0]      sc [12];

	// captured data beat
	logic [7:0]      pb_q;
	logic [G_W-1:0]  grp_q;
	logic [VI_W-1:0] idx_q;
	logic            last_q;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			sc[i]     = scale_bytes_low[8*i +: 8];
			sc[i + 6] = scale_bytes_high[8*i +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsc_q <= '0;
			hmn_q <= '0;
			pos_q <= '0;
			for (int i = 0; i < 8; i++) begin
				gsc_q[i] <= '0;
				gmn_q[i] <= '0;
			end
		end else if (cmd.load_hdr) begin
			hsc_q <= half_scale;
			hmn_q <= half_min;
			pos_q <= '0;
			for (int i = 0; i < 4; i++) begin
				gsc_q[i]     <= 6'(sc[i] & q4kd_pkg::MASK_SIX);
				gsc_q[i + 4] <= {4'(sc[i + 4] & q4kd_pkg::MASK_NIB),
					2'((sc[i] >> 6) & q4kd_pkg::MASK_TWO)};
				gmn_q[i]     <= 6'(sc[i + 8] & q4kd_pkg::MASK_SIX);
				gmn_q[i + 4] <= {4'(sc[i + 4] >> 4),
					2'((sc[i + 8] >> 6) & q4kd_pkg::MASK_TWO)};
			end
		end else if (cmd.load_data) begin
			pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_data) begin
			pb_q   <= packed_byte;
			grp_q  <= pos_q[BP_W-1:4];
			idx_q  <= VI_W'({pos_q, 1'b0});
			last_q <= (pos_q == LAST_POS);
		end
	end

	// stage 1: decode halves, group multiplier products
	logic [10:0]       md, mm;
	logic signed [5:0] ed, em;
	logic [16:0]       gs_s1, gm_s1;
	logic signed [5:0] ed_s1, em_s1;
	logic              sd_s1, sm_s1, dinf_s1, dnan_s1, minf_s1, mnan_s1;
	logic [3:0]        q_s1 [2];

	always_comb begin
		md = {hsc_q[14:10] != 5'd0, hsc_q[9:0]};
		mm = {hmn_q[14:10] != 5'd0, hmn_q[9:0]};
		ed = 6'($signed({2'b0, (hsc_q[14:10] == 5'd0) ? 5'd1 : hsc_q[14:10]}) - 7'sd25);
		em = 6'($signed({2'b0, (hmn_q[14:10] == 5'd0) ? 5'd1 : hmn_q[14:10]}) - 7'sd25);
	end

	always_ff @(posedge clk) begin
		if (cmd.st_mul) begin
			gs_s1   <= md * gsc_q[grp_q];
			gm_s1   <= mm * gmn_q[grp_q];
			ed_s1   <= ed;
			em_s1   <= em;
			sd_s1   <= hsc_q[15];
			sm_s1   <= hmn_q[15];
			dinf_s1 <= (hsc_q[14:10] == 5'h1F) && (hsc_q[9:0] == '0);
			dnan_s1 <= (hsc_q[14:10] == 5'h1F) && (hsc_q[9:0] != '0);
			minf_s1 <= (hmn_q[14:10] == 5'h1F) && (hmn_q[9:0] == '0);
			mnan_s1 <= (hmn_q[14:10] == 5'h1F) && (hmn_q[9:0] != '0);
			q_s1[0] <= pb_q[3:0];
			q_s1[1] <= pb_q[7:4];
		end
	end

	// stage 2: code products and alignment amounts
	logic [20:0]       a_s2 [2];
	logic [16:0]       b_s2;
	logic [4:0]        sha_s2, shb_s2;
	logic signed [5:0] emin_s2;
	logic              sd_s2, sm_s2, dinf_s2, dnan_s2, minf_s2, mnan_s2;

	always_ff @(posedge clk) begin
		if (cmd.st_prod) begin
			a_s2[0] <= gs_s1 * q_s1[0];
			a_s2[1] <= gs_s1 * q_s1[1];
			b_s2    <= gm_s1;
			if (ed_s1 >= em_s1) begin
				sha_s2  <= 5'(ed_s1 - em_s1);
				shb_s2  <= '0;
				emin_s2 <= em_s1;
			end else begin
				sha_s2  <= '0;
				shb_s2  <= 5'(em_s1 - ed_s1);
				emin_s2 <= ed_s1;
			end
			sd_s2   <= sd_s1;
			sm_s2   <= sm_s1;
			dinf_s2 <= dinf_s1;
			dnan_s2 <= dnan_s1;
			minf_s2 <= minf_s1;
			mnan_s2 <= mnan_s1;
		end
	end

	// stage 3: exact signed difference, special values
	logic [MW-1:0]     bb;
	logic [MW-1:0]     aa [2];
	logic signed [MW+1:0] ta [2];
	logic signed [MW+1:0] tb;
	logic signed [MW+1:0] rr [2];
	logic signed [MW+1:0] nr [2];
	logic [MW-1:0]     mag_s3 [2];
	logic              neg_s3 [2], zs_s3 [2], spec_s3 [2];
	logic [31:0]       specv_s3 [2];
	logic signed [5:0] emin_s3;
	logic              anan [2], ainf [2];
	logic              bnan, binf;

	always_comb begin
		bb = MW'(b_s2) << shb_s2;
		tb = sm_s2 ? -$signed({2'b0, bb}) : $signed({2'b0, bb});
		bnan = mnan_s2 || (minf_s2 && b_s2 == '0);
		binf = minf_s2 && b_s2 != '0;
		for (int l = 0; l < 2; l++) begin
			aa[l] = MW'(a_s2[l]) << sha_s2;
			ta[l] = sd_s2 ? -$signed({2'b0, aa[l]}) : $signed({2'b0, aa[l]});
			rr[l] = ta[l] - tb;
			nr[l] = -rr[l];
			anan[l] = dnan_s2 || (dinf_s2 && a_s2[l] == '0);
			ainf[l] = dinf_s2 && a_s2[l] != '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.st_align) begin
			emin_s3 <= emin_s2;
			for (int l = 0; l < 2; l++) begin
				neg_s3[l] <= rr[l][MW+1];
				mag_s3[l] <= rr[l][MW+1] ? nr[l][MW-1:0] : rr[l][MW-1:0];
				zs_s3[l]  <= (a_s2[l] == '0) && (b_s2 == '0) && sd_s2 && !sm_s2;
				spec_s3[l] <= anan[l] || bnan || ainf[l] || binf;
				if (anan[l] || bnan || (ainf[l] && binf && sd_s2 == sm_s2))
					specv_s3[l] <= q4kd_pkg::QNAN_BITS;
				else if (ainf[l])
					specv_s3[l] <= {sd_s2, q4kd_pkg::INF_BITS};
				else
					specv_s3[l] <= {!sm_s2, q4kd_pkg::INF_BITS};
			end
		end
	end

	// stage 4: leading one position
	logic [PW-1:0]     p_c [2];
	logic [PW-1:0]     p_s4 [2];
	logic [MW-1:0]     mag_s4 [2];
	logic              neg_s4 [2], zs_s4 [2], spec_s4 [2];
	logic [31:0]       specv_s4 [2];
	logic signed [5:0] emin_s4;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			p_c[l] = '0;
			for (int k = 0; k < MW; k++)
				if (mag_s3[l][k]) p_c[l] = PW'(k);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.st_scan) begin
			emin_s4 <= emin_s3;
			for (int l = 0; l < 2; l++) begin
				p_s4[l]     <= p_c[l];
				mag_s4[l]   <= mag_s3[l];
				neg_s4[l]   <= neg_s3[l];
				zs_s4[l]    <= zs_s3[l];
				spec_s4[l]  <= spec_s3[l];
				specv_s4[l] <= specv_s3[l];
			end
		end
	end

	// round to nearest even and pack
	logic [31:0]       res [2];
	logic [23:0]       kept [2];
	logic [MW-1:0]     sh_up [2], sh_dn [2], sh_g [2];
	logic              guard [2], sticky [2], rnd [2];
	logic signed [9:0] ef [2];
	logic [30:0]       body [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			ef[l]    = $signed({4'b0, p_s4[l]}) + 10'(emin_s4) + 10'sd127;
			sh_up[l] = mag_s4[l] << (PW'(23) - p_s4[l]);
			sh_dn[l] = mag_s4[l] >> (p_s4[l] - PW'(23));
			sh_g[l]  = mag_s4[l] >> (p_s4[l] - PW'(24));
			if (p_s4[l] <= PW'(23)) begin
				kept[l]   = sh_up[l][23:0];
				guard[l]  = 1'b0;
				sticky[l] = 1'b0;
			end else begin
				kept[l]   = sh_dn[l][23:0];
				guard[l]  = sh_g[l][0];
				sticky[l] = (mag_s4[l] & ((MW'(1) << (p_s4[l] - PW'(24))) - MW'(1))) != '0;
			end
			rnd[l]  = guard[l] && (sticky[l] || kept[l][0]);
			body[l] = {ef[l][7:0], kept[l][22:0]} + 31'(rnd[l]);
			if (spec_s4[l])
				res[l] = specv_s4[l];
			else if (mag_s4[l] == '0)
				res[l] = {zs_s4[l], 31'b0};
			else
				res[l] = {neg_s4[l], body[l]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			low_value   <= res[0];
			high_value  <= res[1];
			value_index <= idx_q;
			block_end   <= last_q;
		end
	end

endmodule
`default_nettype wire

// ===== sv/q4kd_checker.sv =====
// ----------------------------------------------------------------------------
// q4kd_checker
// port level checks of the dequantizer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
module q4kd_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         s_tuser,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [71:0]  m_tdata,
	input wire logic         m_tlast
);

	// a data beat keeps the input closed for the next cycle
	a_busy_after_data: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("input open right after a data beat");

	// a stalled output beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output beat changed");

	// the low value index is always even
	a_even_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[64])
		else $error("odd value index");

	// the block end comes with the last byte position
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[71:64] == 8'd254)
		else $error("block end at wrong index");

endmodule

bind q4_k_block_dequantizer_core q4kd_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

// ===== tb/sv/q4_k_block_dequantizer_core_test.sv =====
// ----------------------------------------------------------------------------
// q4_k_block_dequantizer_core_test
// self-checking stream test of the q4_k block dequantizer
// ----------------------------------------------------------------------------
// Header and data beats go in from a queue through a falling-edge driver. Each
// accepted beat updates a local model of the dequantizer: header state, the
// byte position and an exact integer datapath for d*scale*q - dmin*min with a
// single round-to-nearest-even. A rising-edge monitor checks every output beat
// against the oldest expected one. Both sides pause in random bursts, except
// near the end of the run.
// ----------------------------------------------------------------------------
`default_nettype none
module q4_k_block_dequantizer_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int BLOCK_VALUES_TB = 256;

	typedef struct packed {
		logic         kind;
		logic [135:0] payload;
	} beat_t;

	typedef struct packed {
		logic [31:0] low_value;
		logic [31:0] high_value;
		logic [7:0]  value_index;
		logic        block_end;
	} dq_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic         s_tuser = 1'b0;
	logic [135:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [71:0]  m_tdata;
	logic         m_tlast;

	// beats waiting for the driver and values still to come out
	beat_t      pending_beats[$];
	dq_result_t expected_values[$];

	// model state
	logic [15:0] blk_scale = '0;
	logic [15:0] blk_min = '0;
	logic [5:0]  grp_scale[8];
	logic [5:0]  grp_min[8];
	logic [6:0]  byte_pos = '0;

	int  fail_count = 0;
	int  headers_in = 0;
	int  bytes_in = 0;
	int  values_checked = 0;
	int  quiet_cycles = 0;
	bit  timed_out = 0;
	bit  calm = 0;          // no idling in the last part
	bit  in_taken = 0;      // input beat accepted at the last rising edge
	int  src_gap = 0;
	int  sink_gap = 0;

	q4_k_block_dequantizer_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// binary16 magnitude as an integer count of 2^-24 (finite codes only)
	function automatic longint half_units(logic [15:0] h);
		longint mant;
		mant = h[9:0];
		if (h[14:10] == 5'd0)
			return mant;
		return (mant + 1024) <<< (h[14:10] - 1);
	endfunction

	// one dequantized value as float32 bits: exact products, one rounding
	function automatic logic [31:0] dequant_value(logic [15:0] d, logic [15:0] dm,
			logic [5:0] sc, logic [5:0] mn, logic [3:0] q);
		bit      p_nan, p_inf, m_nan, m_inf, neg;
		longint  prod, offs, diff;
		logic [63:0] mag;
		logic [63:0] mant;
		logic [63:0] rem;
		logic [63:0] half_ulp;
		int      msb, sh;
		p_nan = (d[14:10] == 5'h1F) && (d[9:0] != 0);
		p_inf = (d[14:10] == 5'h1F) && (d[9:0] == 0);
		if (p_inf && (sc == 0 || q == 0)) begin
			p_nan = 1;
			p_inf = 0;
		end
		m_nan = (dm[14:10] == 5'h1F) && (dm[9:0] != 0);
		m_inf = (dm[14:10] == 5'h1F) && (dm[9:0] == 0);
		if (m_inf && mn == 0) begin
			m_nan = 1;
			m_inf = 0;
		end
		if (p_nan || m_nan)
			return q4kd_pkg::QNAN_BITS;
		if (p_inf && m_inf)
			return (d[15] == dm[15]) ? q4kd_pkg::QNAN_BITS : {d[15], q4kd_pkg::INF_BITS};
		if (p_inf)
			return {d[15], q4kd_pkg::INF_BITS};
		if (m_inf)
			return {~dm[15], q4kd_pkg::INF_BITS};
		prod = half_units(d) * sc * q;
		offs = half_units(dm) * mn;
		if (prod == 0 && offs == 0)
			return {d[15] & ~dm[15], 31'd0};
		diff = (d[15] ? -prod : prod) - (dm[15] ? -offs : offs);
		if (diff == 0)
			return 32'd0;
		neg = diff < 0;
		mag = neg ? -diff : diff;
		msb = 0;
		for (int b = 0; b < 64; b++)
			if (mag[b])
				msb = b;
		if (msb <= 23) begin
			mant = mag << (23 - msb);
		end else begin
			sh = msb - 23;
			mant = mag >> sh;
			rem = mag & ((64'd1 << sh) - 1);
			half_ulp = 64'd1 << (sh - 1);
			if (rem > half_ulp || (rem == half_ulp && mant[0]))
				mant = mant + 1;
			if (mant[24]) begin
				mant = mant >> 1;
				msb = msb + 1;
			end
		end
		// value = mag * 2^-24, so the unbiased exponent is msb - 24
		return {neg, 8'(msb - 24 + 127), mant[22:0]};
	endfunction

	// model update for one accepted beat; data beats queue their expected values
	task automatic dequant_accept(beat_t bt);
		logic [7:0] sb[12];
		logic [2:0] g;
		dq_result_t r;
		for (int i = 0; i < 6; i++) begin
			sb[i] = bt.payload[32 + 8*i +: 8];
			sb[i+6] = bt.payload[80 + 8*i +: 8];
		end
		if (bt.kind == q4kd_pkg::KIND_HEADER) begin
			headers_in++;
			blk_scale = bt.payload[15:0];
			blk_min = bt.payload[31:16];
			for (int i = 0; i < 4; i++) begin
				grp_scale[i] = 6'(sb[i] & q4kd_pkg::MASK_SIX);
				grp_scale[i+4] = 6'(((sb[i] >> 6) & q4kd_pkg::MASK_TWO)
					| ((sb[i+4] & q4kd_pkg::MASK_NIB) << 2));
				grp_min[i] = 6'(sb[i+8] & q4kd_pkg::MASK_SIX);
				grp_min[i+4] = 6'(((sb[i+8] >> 6) & q4kd_pkg::MASK_TWO)
					| ((sb[i+4] >> 4) << 2));
			end
			byte_pos = '0;
		end else begin
			bytes_in++;
			g = byte_pos[6:4];
			r.low_value = dequant_value(blk_scale, blk_min, grp_scale[g], grp_min[g],
				bt.payload[131:128]);
			r.high_value = dequant_value(blk_scale, blk_min, grp_scale[g], grp_min[g],
				bt.payload[135:132]);
			r.value_index = {byte_pos, 1'b0};
			r.block_end = (byte_pos == 7'(BLOCK_VALUES_TB/2 - 1));
			expected_values.push_back(r);
			byte_pos = byte_pos + 7'd1;   // wraps to 0 after the last byte
		end
	endtask

	// random header with mostly ordinary multipliers, sometimes special codes
	function automatic beat_t make_header(bit any_half);
		beat_t bt;
		bt.kind = q4kd_pkg::KIND_HEADER;
		bt.payload = {$urandom, $urandom, $urandom, $urandom, 8'($urandom)};
		if (!any_half) begin
			bt.payload[15:0] = {1'($urandom), 5'($urandom_range(1, 30)), 10'($urandom)};
			bt.payload[31:16] = {1'($urandom), 5'($urandom_range(0, 30)), 10'($urandom)};
		end
		return bt;
	endfunction

	function automatic beat_t make_data(logic [7:0] pb);
		beat_t bt;
		bt.kind = q4kd_pkg::KIND_DATA;
		bt.payload = {pb, $urandom, $urandom, $urandom, $urandom};
		return bt;
	endfunction

	// driver: new beat or idle at the falling edge
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				src_gap <= $urandom_range(0, 11);
				s_tvalid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				beat_t bt;
				bt = pending_beats.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= bt.kind;
				s_tdata <= bt.payload;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		// sink back-pressure
		if (arst_n) begin
			if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				sink_gap <= $urandom_range(0, 11);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor: check outputs, then feed accepted inputs to the model
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				dq_result_t e;
				if (expected_values.size() == 0) begin
					$error("output beat with nothing expected: %h", m_tdata);
					fail_count++;
				end else begin
					e = expected_values.pop_front();
					values_checked++;
					if (m_tdata[31:0] !== e.low_value) begin
						$error("low_value expected %h got %h", e.low_value, m_tdata[31:0]);
						fail_count++;
					end
					if (m_tdata[63:32] !== e.high_value) begin
						$error("high_value expected %h got %h", e.high_value, m_tdata[63:32]);
						fail_count++;
					end
					if (m_tdata[71:64] !== e.value_index) begin
						$error("value_index expected %0d got %0d", e.value_index,
							m_tdata[71:64]);
						fail_count++;
					end
					if (m_tlast !== e.block_end) begin
						$error("block_end expected %b got %b", e.block_end, m_tlast);
						fail_count++;
					end
				end
			end
			in_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				dequant_accept('{kind: s_tuser, payload: s_tdata});
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		beat_t bt;
		int    run_len;
		for (int i = 0; i < 8; i++) begin
			grp_scale[i] = '0;
			grp_min[i] = '0;
		end

		// directed: data before any header gives +0
		pending_beats.push_back(make_data(8'h00));
		pending_beats.push_back(make_data(8'hFF));
		// all-ones scale bytes, largest finite multipliers
		bt = make_header(1);
		bt.payload[127:32] = '1;
		bt.payload[31:0] = {16'h7BFF, 16'h7BFF};
		pending_beats.push_back(bt);
		pending_beats.push_back(make_data(8'hF0));
		pending_beats.push_back(make_data(8'h0F));
		// subnormal multipliers, zero scale bytes: signed zeros
		bt = make_header(1);
		bt.payload[127:32] = '0;
		bt.payload[31:0] = {16'h0000, 16'h8000};
		pending_beats.push_back(bt);
		pending_beats.push_back(make_data(8'h5A));
		bt.payload[31:0] = {16'h8001, 16'h03FF};
		bt.payload[127:32] = {12{8'hC1}};
		pending_beats.push_back(bt);
		pending_beats.push_back(make_data(8'h00));
		pending_beats.push_back(make_data(8'h81));
		// infinite scale: inf*0 is nan, inf minus inf of same sign is nan
		bt.payload[31:0] = {16'h7C00, 16'h7C00};
		pending_beats.push_back(bt);
		pending_beats.push_back(make_data(8'h10));
		pending_beats.push_back(make_data(8'h33));
		bt.payload[31:0] = {16'h7C00, 16'hFC00};
		pending_beats.push_back(bt);
		pending_beats.push_back(make_data(8'h21));
		// nan multiplier
		bt.payload[31:0] = {16'h3C00, 16'h7E01};
		pending_beats.push_back(bt);
		pending_beats.push_back(make_data(8'hA7));
		bt.payload[31:0] = {16'hFFFF, 16'h3C00};
		pending_beats.push_back(bt);
		pending_beats.push_back(make_data(8'h7E));

		// random: mostly header followed by a run of bytes, some full blocks
		while (pending_beats.size() < 700) begin
			pending_beats.push_back(make_header($urandom_range(0, 7) == 0));
			case ($urandom_range(0, 3))
				0: run_len = 128;
				1: run_len = 128 + $urandom_range(1, 20);   // wrap reuses the header
				default: run_len = $urandom_range(0, 40);
			endcase
			for (int i = 0; i < run_len && pending_beats.size() < 700; i++)
				pending_beats.push_back(make_data(8'($urandom)));
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_beats.size() < 60);
		calm = 1;
		wait (pending_beats.size() == 0 && !s_tvalid && expected_values.size() == 0);
		repeat (20) @(posedge clk);

		$display("%0d headers and %0d data bytes sent, %0d output beats checked",
			headers_in, bytes_in, values_checked);
		$display("covered reset state, signed zeros, subnormals, inf and nan multipliers, wraps");
		if (fail_count == 0 && expected_values.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/q4kd_pkg.sv
sv/q4kd_ctrl.sv
sv/q4kd_dp.sv
sv/q4_k_block_dequantizer_core.sv
sv/q4kd_checker.sv
tb/sv/q4_k_block_dequantizer_core_test.sv
